[design/tfh_pkg.sv]
// ----------------------------------------------------------------------------
// tfh_pkg
// shared types, title tables and result codes of the titled frame hunter
// ----------------------------------------------------------------------------
package tfh_pkg;

   localparam int FRAME_BUF  = 2048;
   localparam int CNT_W      = $clog2(FRAME_BUF);
   localparam int FLEN_W     = 11;
   localparam int NUM_TITLES = 3;
   localparam int WIN_DEPTH  = 8;
   localparam int FILL_W     = $clog2(WIN_DEPTH);
   localparam int LEN_W      = FILL_W + 1;

   typedef logic [7:0] byte_type;

   localparam byte_type CH_DOLLAR = 8'h24;
   localparam byte_type CH_CR     = 8'h0d;
   localparam byte_type CH_LF     = 8'h0a;

   typedef enum logic [2:0] {
      ST_HUNT  = 3'd0,
      ST_TITLE = 3'd1,
      ST_BODY  = 3'd2,
      ST_DONE  = 3'd3,
      ST_OVFL  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_INITACK = 2'd1,
      KIND_PONG    = 2'd2,
      KIND_MESSAGE = 2'd3
   } kind_type;

   // "$initack", "$pong", "$message"
   localparam byte_type TITLE_TEXT [NUM_TITLES][WIN_DEPTH] = '{
      '{8'h24, 8'h69, 8'h6e, 8'h69, 8'h74, 8'h61, 8'h63, 8'h6b},
      '{8'h24, 8'h70, 8'h6f, 8'h6e, 8'h67, 8'h00, 8'h00, 8'h00},
      '{8'h24, 8'h6d, 8'h65, 8'h73, 8'h73, 8'h61, 8'h67, 8'h65}
   };

   localparam logic [LEN_W-1:0] TITLE_LEN [NUM_TITLES] = '{
      LEN_W'(8), LEN_W'(5), LEN_W'(8)
   };

   localparam kind_type KIND_OF [NUM_TITLES] = '{KIND_INITACK, KIND_PONG, KIND_MESSAGE};

   function automatic byte_type title_xor(input int t);
      byte_type x;
      x = '0;
      for (int i = 0; i < WIN_DEPTH; i++) begin
         if (i < int'(TITLE_LEN[t])) begin
            x = x ^ TITLE_TEXT[t][i];
         end
      end
      return x;
   endfunction

   localparam byte_type TITLE_XOR [NUM_TITLES] = '{title_xor(0), title_xor(1), title_xor(2)};

   typedef struct packed {
      status_type          status;
      kind_type            kind;
      logic [FLEN_W-1:0]   frame_len;
      byte_type            xor_sum;
      byte_type            body_byte;
   } result_type;

endpackage

[design/tfh_in_stage.sv]
// ----------------------------------------------------------------------------
// tfh_in_stage
// input register for received bytes
// ----------------------------------------------------------------------------
module tfh_in_stage
   import tfh_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  byte_type req_tdata,   // [7:0] data_byte
   input  logic     advance,
   output logic     in_valid,
   output byte_type in_byte
);

   logic     valid_ff, valid_in;
   byte_type byte_ff, byte_in;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign in_valid = valid_ff;
   assign in_byte  = byte_ff;

endmodule

[design/tfh_core.sv]
// ----------------------------------------------------------------------------
// tfh_core
// title hunt and frame tracking state with the per-byte result logic
// ----------------------------------------------------------------------------
module tfh_core
   import tfh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  byte_type   in_byte,
   input  logic       advance,
   output result_type result
);

   // window kept as fill count plus the set of titles it is still a prefix of
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [NUM_TITLES-1:0] alive_ff, alive_in;
   logic                  in_frame_ff, in_frame_in;
   kind_type              kind_ff, kind_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   byte_type              xor_ff, xor_in;
   logic                  cr_ff, cr_in;

   logic [NUM_TITLES-1:0] alive_next;
   logic                  hit;
   logic [1:0]            hit_idx;
   logic [LEN_W-1:0]      fill_plus;
   logic [CNT_W-1:0]      count_plus;
   byte_type              xor_plus;

   assign fill_plus  = {1'b0, fill_ff} + LEN_W'(1);
   assign count_plus = count_ff + CNT_W'(1);
   assign xor_plus   = xor_ff ^ in_byte;

   always_comb begin
      hit     = 1'b0;
      hit_idx = '0;
      for (int t = 0; t < NUM_TITLES; t++) begin
         if (fill_ff == '0) begin
            alive_next[t] = (in_byte == CH_DOLLAR);
         end else begin
            alive_next[t] = alive_ff[t] && ({1'b0, fill_ff} < TITLE_LEN[t])
                            && (in_byte == TITLE_TEXT[t][fill_ff]);
         end
      end
      for (int t = NUM_TITLES - 1; t >= 0; t--) begin
         if (alive_next[t] && (fill_plus == TITLE_LEN[t])) begin
            hit     = 1'b1;
            hit_idx = 2'(t);
         end
      end
   end

   always_comb begin
      fill_in     = fill_ff;
      alive_in    = alive_ff;
      in_frame_in = in_frame_ff;
      kind_in     = kind_ff;
      count_in    = count_ff;
      xor_in      = xor_ff;
      cr_in       = cr_ff;

      result.status    = ST_HUNT;
      result.kind      = KIND_NONE;
      result.frame_len = '0;
      result.xor_sum   = '0;
      result.body_byte = '0;

      if (!in_frame_ff) begin
         if (hit) begin
            in_frame_in = 1'b1;
            kind_in     = KIND_OF[hit_idx];
            count_in    = CNT_W'(TITLE_LEN[hit_idx]);
            xor_in      = TITLE_XOR[hit_idx];
            cr_in       = 1'b0;
            fill_in     = '0;
            alive_in    = '0;
            result.status    = ST_TITLE;
            result.kind      = KIND_OF[hit_idx];
            result.frame_len = FLEN_W'(TITLE_LEN[hit_idx]);
            result.xor_sum   = TITLE_XOR[hit_idx];
         end else if (|alive_next) begin
            fill_in  = fill_plus[FILL_W-1:0];
            alive_in = alive_next;
         end else if (in_byte == CH_DOLLAR) begin
            fill_in  = FILL_W'(1);
            alive_in = '1;
         end else begin
            fill_in  = '0;
            alive_in = '0;
         end
      end else begin
         count_in = count_plus;
         xor_in   = xor_plus;
         result.kind      = kind_ff;
         result.frame_len = FLEN_W'(count_plus);
         result.xor_sum   = xor_plus;
         if (count_plus >= CNT_W'(FRAME_BUF - 1)) begin
            result.status = ST_OVFL;
         end else if ((in_byte == CH_LF) && cr_ff) begin
            result.status    = ST_DONE;
            result.body_byte = in_byte;
         end else begin
            result.status    = ST_BODY;
            result.body_byte = in_byte;
            cr_in            = (in_byte == CH_CR);
         end
         if (result.status != ST_BODY) begin
            in_frame_in = 1'b0;
            kind_in     = KIND_NONE;
            count_in    = '0;
            xor_in      = '0;
            cr_in       = 1'b0;
            fill_in     = '0;
            alive_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         alive_ff    <= '0;
         in_frame_ff <= 1'b0;
         kind_ff     <= KIND_NONE;
         count_ff    <= '0;
         xor_ff      <= '0;
         cr_ff       <= 1'b0;
      end else if (advance) begin
         fill_ff     <= fill_in;
         alive_ff    <= alive_in;
         in_frame_ff <= in_frame_in;
         kind_ff     <= kind_in;
         count_ff    <= count_in;
         xor_ff      <= xor_in;
         cr_ff       <= cr_in;
      end
   end

endmodule

[design/tfh_out_stage.sv]
// ----------------------------------------------------------------------------
// tfh_out_stage
// result register driving the response channel
// ----------------------------------------------------------------------------
module tfh_out_stage
   import tfh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  result,
   output logic        stall,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] frame_len, [18:11] xor_sum, [26:19] body_byte
   output logic [4:0]  rsp_tuser    // [2:0] status, [4:3] msg_kind
);

   logic       valid_ff, valid_in;
   result_type res_ff, res_in;

   assign stall = valid_ff && !rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b1;
         res_in   = result;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, res_ff.body_byte, res_ff.xor_sum, res_ff.frame_len};
   assign rsp_tuser  = {res_ff.kind, res_ff.status};

endmodule

[design/titled_crlf_frame_hunter_top.sv]
// ----------------------------------------------------------------------------
// titled_crlf_frame_hunter_top
// byte stream framer for titled sentences ended by cr lf
// ----------------------------------------------------------------------------
// bytes enter on the req_ stream, one per item; every byte yields exactly one
// item on the rsp_ stream, carrying status and msg_kind in tuser and
// frame_len, xor_sum and body_byte in tdata
// while hunting, a title ("$initack", "$pong", "$message") is matched as the
// bytes arrive; after a title every byte is body until cr lf or overflow
// a byte accepted is held in the input register; its result is loaded into the
// output register when the rsp_ stream is not stalled and is driven from there
// throughput: one item per cycle while rsp_tready keeps the output from
// stalling; the next-state and result logic between the two registers is combinational
// reset: both registers empty, hunting with an empty title window
// stall: a result held by rsp_tready low stays put; one more byte is taken
// into the input register, then req_tready drops until the result leaves
// ----------------------------------------------------------------------------
module titled_crlf_frame_hunter_top
   import tfh_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [10:0] frame_len, [18:11] xor_sum, [26:19] body_byte
   output logic [4:0]  rsp_tuser    // [2:0] status, [4:3] msg_kind
);

   logic       in_valid;
   byte_type   in_byte;
   logic       advance;
   logic       stall;
   result_type result;

   assign advance = in_valid && !stall;

   tfh_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .in_valid   (in_valid),
      .in_byte    (in_byte)
   );

   tfh_core u_core (
      .clock   (clock),
      .reset   (reset),
      .in_byte (in_byte),
      .advance (advance),
      .result  (result)
   );

   tfh_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .stall      (stall),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// byte stream checker for the titled cr lf frame hunter
// ----------------------------------------------------------------------------
// a short table of bytes covers hunting on junk, a sliding title window,
// the pong and initack titles, lf with and without a preceding cr and a body
// byte of ff; two long frames follow, one ending on cr lf just
// short of the buffer limit and one running into overflow; random sentences,
// broken titles and noise make up the rest. every byte is run through a
// local model of the framer and each rsp item is compared field by field.
// the sender works in bursts with gaps, the receiver stalls in changing modes
// ----------------------------------------------------------------------------
module testbench;
   import tfh_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 850;
   localparam int DRAIN_CYCLES = 8;
   localparam int TABLE_ROWS   = 25;

   typedef struct packed {
      byte_type   data;
      logic       typed;
      result_type want;
   } step_row_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_COMB,
      RX_CHOKE
   } rx_mode_type;

   localparam result_type HUNT_RESULT = '0;

   localparam step_row_type STEP_TABLE [TABLE_ROWS] = '{
      '{8'h00,     1'b1, HUNT_RESULT},
      '{8'hff,     1'b1, HUNT_RESULT},
      '{CH_DOLLAR, 1'b1, HUNT_RESULT},
      '{CH_DOLLAR, 1'b1, HUNT_RESULT},
      '{"p",       1'b1, HUNT_RESULT},
      '{"o",       1'b1, HUNT_RESULT},
      '{"n",       1'b1, HUNT_RESULT},
      '{"g",       1'b0, HUNT_RESULT},
      '{CH_CR,     1'b0, HUNT_RESULT},
      '{CH_LF,     1'b0, HUNT_RESULT},
      '{CH_DOLLAR, 1'b1, HUNT_RESULT},
      '{"i",       1'b1, HUNT_RESULT},
      '{"n",       1'b1, HUNT_RESULT},
      '{"i",       1'b1, HUNT_RESULT},
      '{"t",       1'b1, HUNT_RESULT},
      '{"a",       1'b1, HUNT_RESULT},
      '{"c",       1'b1, HUNT_RESULT},
      '{"k",       1'b0, HUNT_RESULT},
      '{CH_LF,     1'b0, HUNT_RESULT},
      '{CH_CR,     1'b0, HUNT_RESULT},
      '{8'hff,     1'b0, HUNT_RESULT},
      '{CH_CR,     1'b0, HUNT_RESULT},
      '{CH_LF,     1'b0, HUNT_RESULT},
      '{CH_DOLLAR, 1'b1, HUNT_RESULT},
      '{"m",       1'b1, HUNT_RESULT}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;           // [10:0] frame_len, [18:11] xor_sum, [26:19] body_byte
   logic [4:0]  rsp_tuser;           // [2:0] status, [4:3] msg_kind

   string title_names [3] = '{"$initack", "$pong", "$message"};

   // framer model state
   byte_type win [WIN_DEPTH] = '{default: 8'h00};
   int       win_fill = 0;
   logic     framing = 1'b0;
   kind_type cur_kind = KIND_NONE;
   int       len_count = 0;
   byte_type run_xor = 8'h00;
   logic     saw_cr = 1'b0;

   result_type  result_due_q [$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   rx_mode_type stall_mode = RX_OPEN;
   int          stall_span = 0;

   titled_crlf_frame_hunter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic window_prefix();
      logic ok;
      for (int t = 0; t < 3; t++) begin
         ok = win_fill <= title_names[t].len();
         for (int i = 0; ok && i < win_fill; i++) begin
            if (win[i] != byte_type'(title_names[t][i])) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic int window_title();
      logic ok;
      for (int t = 0; t < 3; t++) begin
         ok = win_fill == title_names[t].len();
         for (int i = 0; ok && i < win_fill; i++) begin
            if (win[i] != byte_type'(title_names[t][i])) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            return t + 1;
         end
      end
      return 0;
   endfunction

   // drop leading bytes up to the next dollar after the first one
   function automatic void slide_window();
      int s;
      s = 1;
      while (s < win_fill && win[s] != CH_DOLLAR) begin
         s++;
      end
      if (s < win_fill) begin
         for (int j = 0; j + s < win_fill; j++) begin
            win[j] = win[j + s];
         end
         win_fill -= s;
      end else begin
         win_fill = 0;
      end
   endfunction

   function automatic void drop_frame();
      framing   = 1'b0;
      cur_kind  = KIND_NONE;
      len_count = 0;
      run_xor   = 8'h00;
      saw_cr    = 1'b0;
      win_fill  = 0;
   endfunction

   function automatic result_type frame_hunt_step(input byte_type b);
      result_type r;
      int         hit;
      byte_type   x;
      r = '0;
      if (!framing) begin
         if (win_fill >= WIN_DEPTH) begin
            slide_window();
         end
         if (win_fill >= WIN_DEPTH) begin
            win_fill = 0;
         end
         win[win_fill] = b;
         win_fill++;
         while (win_fill > 0 && !window_prefix()) begin
            slide_window();
         end
         hit = window_title();
         if (hit != 0) begin
            x = 8'h00;
            for (int i = 0; i < win_fill; i++) begin
               x ^= win[i];
            end
            framing     = 1'b1;
            cur_kind    = kind_type'(hit);
            len_count   = win_fill;
            run_xor     = x;
            saw_cr      = 1'b0;
            win_fill    = 0;
            r.status    = ST_TITLE;
            r.kind      = cur_kind;
            r.frame_len = FLEN_W'(len_count);
            r.xor_sum   = x;
         end
      end else begin
         len_count++;
         run_xor ^= b;
         r.kind      = cur_kind;
         r.frame_len = FLEN_W'(len_count);
         r.xor_sum   = run_xor;
         if (len_count >= FRAME_BUF - 1) begin
            r.status = ST_OVFL;
            drop_frame();
         end else if (b == CH_LF && saw_cr) begin
            r.status    = ST_DONE;
            r.body_byte = b;
            drop_frame();
         end else begin
            r.status    = ST_BODY;
            r.body_byte = b;
            saw_cr      = (b == CH_CR);
         end
      end
      return r;
   endfunction

   // random byte leaning toward cr, lf, dollar and title letters
   function automatic byte_type stream_byte();
      case ($urandom_range(0, 9))
         0: return CH_CR;
         1: return CH_LF;
         2: return CH_DOLLAR;
         3: return byte_type'(title_names[$urandom_range(0, 2)][$urandom_range(1, 4)]);
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic flag_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
      if (mismatch_count < 30) begin
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic feed_byte(input byte_type b, input logic typed, input result_type want);
      result_type guess;
      int         gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 99) < 55) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      burst_left--;
      guess = frame_hunt_step(b);
      result_due_q.push_back(typed ? want : guess);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("testbench: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_mode <= rx_mode_type'($urandom_range(0, 3));
         stall_span <= $urandom_range(16, 96);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_mode)
         RX_OPEN:  rsp_tready <= 1'b1;
         RX_COIN:  rsp_tready <= 1'($urandom_range(0, 1));
         RX_COMB:  rsp_tready <= (stall_span % 4) != 0;
         default:  rsp_tready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      result_type due;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_due_q.size() == 0) begin
            flag_field("unexpected item", {rsp_tuser, rsp_tdata[26:0]}, 32'h0);
         end else begin
            due = result_due_q.pop_front();
            if (rsp_tuser[2:0] !== due.status) begin
               flag_field("status", 32'(rsp_tuser[2:0]), 32'(due.status));
            end
            if (rsp_tuser[4:3] !== due.kind) begin
               flag_field("msg_kind", 32'(rsp_tuser[4:3]), 32'(due.kind));
            end
            if (rsp_tdata[10:0] !== due.frame_len) begin
               flag_field("frame_len", 32'(rsp_tdata[10:0]), 32'(due.frame_len));
            end
            if (rsp_tdata[18:11] !== due.xor_sum) begin
               flag_field("xor_sum", 32'(rsp_tdata[18:11]), 32'(due.xor_sum));
            end
            if (rsp_tdata[26:19] !== due.body_byte) begin
               flag_field("body_byte", 32'(rsp_tdata[26:19]), 32'(due.body_byte));
            end
            if (rsp_tdata[31:27] !== 5'b0) begin
               flag_field("tdata pad", 32'(rsp_tdata[31:27]), 32'h0);
            end
         end
      end
   end

   initial begin
      byte_type chunk [$];
      int       pick;
      int       t;
      int       n;
      int       random_sent;
      random_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (STEP_TABLE[i]) begin
         feed_byte(STEP_TABLE[i].data, STEP_TABLE[i].typed, STEP_TABLE[i].want);
      end

      // pong frame closing just below the limit, then initack frame overflowing on its lf
      for (int k = 0; k < 2; k++) begin
         chunk.delete();
         t = (k == 0) ? 1 : 0;
         n = (k == 0) ? FRAME_BUF - 2 : FRAME_BUF - 1;
         for (int i = 0; i < title_names[t].len(); i++) begin
            chunk.push_back(byte_type'(title_names[t][i]));
         end
         while (chunk.size() < n - 2) begin
            chunk.push_back(byte_type'($urandom_range(8'h20, 8'h7e)));
         end
         chunk.push_back(CH_CR);
         chunk.push_back(CH_LF);
         foreach (chunk[i]) begin
            feed_byte(chunk[i], 1'b0, HUNT_RESULT);
         end
      end

      while (random_sent < RANDOM_ITEMS) begin
         chunk.delete();
         pick = $urandom_range(0, 99);
         t = $urandom_range(0, 2);
         if (pick < 70) begin
            // title and body with optional junk ahead, usually closed by cr lf
            repeat ($urandom_range(0, 3)) chunk.push_back(byte_type'($urandom_range(0, 255)));
            for (int i = 0; i < title_names[t].len(); i++) begin
               chunk.push_back(byte_type'(title_names[t][i]));
            end
            repeat ($urandom_range(0, 24)) chunk.push_back(stream_byte());
            if ($urandom_range(0, 99) < 85) begin
               chunk.push_back(CH_CR);
               chunk.push_back(CH_LF);
            end
         end else if (pick < 85) begin
            // title cut short
            n = $urandom_range(1, title_names[t].len() - 1);
            for (int i = 0; i < n; i++) begin
               chunk.push_back(byte_type'(title_names[t][i]));
            end
            repeat ($urandom_range(1, 4)) chunk.push_back(stream_byte());
         end else begin
            repeat ($urandom_range(4, 16)) chunk.push_back(stream_byte());
         end
         foreach (chunk[i]) begin
            feed_byte(chunk[i], 1'b0, HUNT_RESULT);
         end
         random_sent += chunk.size();
      end

      req_tvalid <= 1'b0;
      while (result_due_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

[files.f]
design/tfh_pkg.sv
design/tfh_in_stage.sv
design/tfh_core.sv
design/tfh_out_stage.sv
design/titled_crlf_frame_hunter_top.sv
bench/testbench.sv
